>>> design/iq_phase_amplitude_demodulator_core_defines.svh
// Assertion macros shared by the demodulator checker
`ifndef IQ_PHASE_AMPLITUDE_DEMODULATOR_CORE_DEFINES_SVH
`define IQ_PHASE_AMPLITUDE_DEMODULATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define IPAD_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("ipad assertion failed");

// Next-cycle implication, disabled during reset
`define IPAD_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("ipad assertion failed");

`endif

>>> design/ipad_pkg.sv
// Package: types, constants and tables of the IQ demodulator
package ipad_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int DIFF_W       = SAMPLE_W + 1;
  localparam int COEF_W       = 16;
  localparam int ACC_W        = 48;
  localparam int CNT_W        = 13;
  localparam int IDX_W        = 4;
  localparam int MAX_PAIRS    = 4096;
  localparam int TABLE_LENGTH = 10;
  localparam int AVG_W        = 32;
  localparam int MUL_W        = 32;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int ROOT_W       = PROD_W / 2;
  localparam int OUT_W        = 16;
  localparam int DIV_STEPS    = ACC_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int SQRT_STEPS   = ROOT_W;
  localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);
  localparam int CORDIC_STEPS = 18;
  localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS);
  localparam int CORDIC_SCALE = 24;
  localparam int CORDIC_W     = 60;
  localparam int ANGLE_W      = 22;
  localparam int HALF_TURN    = 524288;
  localparam int MAG_ROUND    = 16384;
  localparam int MAG_SHIFT    = 15;
  localparam int DELAY_ROUND  = 32768;

  localparam logic [OUT_W-1:0] PERIOD_RESET = 16'd25000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic                last;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] magnitude;
    logic [OUT_W-1:0] phase_turns;
    logic [OUT_W-1:0] delay_ns;
    logic [CNT_W-1:0] pairs_used;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MAC_I,
    S_MAC_Q,
    S_MAC_END,
    S_DIV_I_GO,
    S_DIV_I_WAIT,
    S_DIV_Q_GO,
    S_DIV_Q_WAIT,
    S_SQ_I,
    S_SQ_Q,
    S_SQ_SUM,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_CORDIC_GO,
    S_CORDIC_WAIT,
    S_DELAY_MUL,
    S_DELAY_END,
    S_OUT
  } state_t;

  function automatic logic signed [COEF_W-1:0] cos_q15(input logic [IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] v;
    begin
      case (idx)
        4'd0: v = 16'sd32767;
        4'd1: v = 16'sd26510;
        4'd2: v = 16'sd10126;
        4'd3: v = -16'sd10126;
        4'd4: v = -16'sd26510;
        4'd5: v = -16'sd32768;
        4'd6: v = -16'sd26510;
        4'd7: v = -16'sd10126;
        4'd8: v = 16'sd10126;
        4'd9: v = 16'sd26510;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  function automatic logic signed [COEF_W-1:0] sin_q15(input logic [IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] v;
    begin
      case (idx)
        4'd0: v = 16'sd0;
        4'd1: v = 16'sd19261;
        4'd2: v = 16'sd31164;
        4'd3: v = 16'sd31164;
        4'd4: v = 16'sd19261;
        4'd5: v = 16'sd0;
        4'd6: v = -16'sd19261;
        4'd7: v = -16'sd31164;
        4'd8: v = -16'sd31164;
        4'd9: v = -16'sd19261;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

  // atan(2^-i) in units of 2^-20 turn
  function automatic logic signed [ANGLE_W-1:0] atan_step(
    input logic [CORDIC_CNT_W-1:0] i
  );
    logic signed [ANGLE_W-1:0] v;
    begin
      case (i)
        5'd0:  v = 22'sd131072;
        5'd1:  v = 22'sd77376;
        5'd2:  v = 22'sd40884;
        5'd3:  v = 22'sd20753;
        5'd4:  v = 22'sd10417;
        5'd5:  v = 22'sd5213;
        5'd6:  v = 22'sd2607;
        5'd7:  v = 22'sd1304;
        5'd8:  v = 22'sd652;
        5'd9:  v = 22'sd326;
        5'd10: v = 22'sd163;
        5'd11: v = 22'sd81;
        5'd12: v = 22'sd41;
        5'd13: v = 22'sd20;
        5'd14: v = 22'sd10;
        5'd15: v = 22'sd5;
        5'd16: v = 22'sd3;
        5'd17: v = 22'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> design/ipad_mul.sv
// Shared signed multiplier with registered product
module ipad_mul (
  input  logic                                clk,
  input  logic signed [ipad_pkg::MUL_W-1:0]   a,
  input  logic signed [ipad_pkg::MUL_W-1:0]   b,
  output logic signed [ipad_pkg::PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> design/ipad_div.sv
// Bit-serial rounded average: acc / n, halves away from zero, saturated
module ipad_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [ipad_pkg::ACC_W-1:0]  acc,
  input  logic [ipad_pkg::CNT_W-1:0]         n,
  output logic                               done,
  output logic signed [ipad_pkg::AVG_W-1:0]  avg
);

  logic                              busy;
  logic [ipad_pkg::DIV_CNT_W-1:0]    cnt;
  logic                              neg;
  logic [ipad_pkg::ACC_W-1:0]        num;
  logic [ipad_pkg::CNT_W-1:0]        rem;
  logic [ipad_pkg::CNT_W-1:0]        divisor;
  logic [ipad_pkg::ACC_W-1:0]        mag;
  logic [ipad_pkg::CNT_W:0]          rem_sh;
  logic [ipad_pkg::CNT_W:0]          diff;
  logic                              fits;

  always_comb begin
    mag    = acc[ipad_pkg::ACC_W-1] ? ipad_pkg::ACC_W'(-acc) : ipad_pkg::ACC_W'(acc);
    rem_sh = {rem, num[ipad_pkg::ACC_W-1]};
    diff   = rem_sh - {1'b0, divisor};
    fits   = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ipad_pkg::DIV_CNT_W'(ipad_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      neg     <= acc[ipad_pkg::ACC_W-1];
      num     <= mag + ipad_pkg::ACC_W'(n >> 1);
      rem     <= '0;
      divisor <= n;
    end else if (busy) begin
      num <= {num[ipad_pkg::ACC_W-2:0], fits};
      rem <= fits ? diff[ipad_pkg::CNT_W-1:0] : rem_sh[ipad_pkg::CNT_W-1:0];
    end
  end

  // Saturate the quotient into the 32-bit signed range
  always_comb begin
    if (neg) begin
      if (num > ipad_pkg::ACC_W'(64'd2147483648))
        avg = {1'b1, {(ipad_pkg::AVG_W-1){1'b0}}};
      else
        avg = -$signed(num[ipad_pkg::AVG_W-1:0]);
    end else begin
      if (num > ipad_pkg::ACC_W'(64'd2147483647))
        avg = {1'b0, {(ipad_pkg::AVG_W-1){1'b1}}};
      else
        avg = $signed(num[ipad_pkg::AVG_W-1:0]);
    end
  end

endmodule

>>> design/ipad_sqrt.sv
// Two-bits-per-cycle floor square root of a 64-bit value
module ipad_sqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ipad_pkg::PROD_W-1:0]        value,
  output logic                               done,
  output logic [ipad_pkg::ROOT_W-1:0]        root
);

  logic                               busy;
  logic [ipad_pkg::SQRT_CNT_W-1:0]    cnt;
  logic [ipad_pkg::PROD_W-1:0]        val;
  logic [ipad_pkg::ROOT_W+1:0]        rem;
  logic [ipad_pkg::ROOT_W+3:0]        rem_sh;
  logic [ipad_pkg::ROOT_W+3:0]        trial;
  logic [ipad_pkg::ROOT_W+3:0]        diff;
  logic                               fits;

  always_comb begin
    rem_sh = {rem, val[ipad_pkg::PROD_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    diff   = rem_sh - trial;
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ipad_pkg::SQRT_CNT_W'(ipad_pkg::SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      val  <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      val  <= {val[ipad_pkg::PROD_W-3:0], 2'b00};
      rem  <= fits ? diff[ipad_pkg::ROOT_W+1:0] : rem_sh[ipad_pkg::ROOT_W+1:0];
      root <= {root[ipad_pkg::ROOT_W-2:0], fits};
    end
  end

endmodule

>>> design/ipad_cordic.sv
// Vectoring CORDIC, one micro-rotation per cycle, angle in 2^-20 turn
module ipad_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [ipad_pkg::AVG_W-1:0]    i_in,
  input  logic signed [ipad_pkg::AVG_W-1:0]    q_in,
  output logic                                 done,
  output logic signed [ipad_pkg::ANGLE_W-1:0]  z
);

  localparam int PadW = ipad_pkg::CORDIC_W - ipad_pkg::AVG_W - ipad_pkg::CORDIC_SCALE;

  logic                                  busy;
  logic [ipad_pkg::CORDIC_CNT_W-1:0]     step;
  logic signed [ipad_pkg::CORDIC_W-1:0]  x;
  logic signed [ipad_pkg::CORDIC_W-1:0]  y;
  logic signed [ipad_pkg::CORDIC_W-1:0]  x0;
  logic signed [ipad_pkg::CORDIC_W-1:0]  y0;
  logic signed [ipad_pkg::CORDIC_W-1:0]  xs;
  logic signed [ipad_pkg::CORDIC_W-1:0]  ys;

  always_comb begin
    x0 = {{PadW{i_in[ipad_pkg::AVG_W-1]}}, i_in, {ipad_pkg::CORDIC_SCALE{1'b0}}};
    y0 = {{PadW{q_in[ipad_pkg::AVG_W-1]}}, q_in, {ipad_pkg::CORDIC_SCALE{1'b0}}};
    xs = x >>> step;
    ys = y >>> step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == ipad_pkg::CORDIC_CNT_W'(ipad_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      // Fold the left half-plane over and start half a turn in
      if (i_in[ipad_pkg::AVG_W-1]) begin
        x <= -x0;
        y <= -y0;
        z <= ipad_pkg::ANGLE_W'(ipad_pkg::HALF_TURN);
      end else begin
        x <= x0;
        y <= y0;
        z <= '0;
      end
    end else if (busy) begin
      if (!y[ipad_pkg::CORDIC_W-1]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ipad_pkg::atan_step(step);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ipad_pkg::atan_step(step);
      end
    end
  end

endmodule

>>> design/iq_phase_amplitude_demodulator_core.sv
// Top level: IQ phase and amplitude demodulator with sequencer
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------
//  in      | in  | in_valid / in_ready  | in_data  (sample_a, sample_b, last)
//  out     | out | out_valid/ out_ready | out_data (magnitude, phase_turns,
//          |     |                      |           delay_ns, pairs_used)
//  cfg     | in  | cfg_wr_en            | cfg_wr_data (transducer period, ns)
//
// A pair is accepted and then takes three multiply/accumulate steps through
// the one shared multiplier; a pair past the capacity is only accepted. A
// last pair then runs the finish: two divisions, the squares and their sum,
// the root, the CORDIC (skipped for a zero vector), the delay and hand-off.
// Synchronous reset clears the accumulators, counters and handshake state.
// A result waiting on out_ready stalls only the end of the next finish.
module iq_phase_amplitude_demodulator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  ipad_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output ipad_pkg::out_t                 out_data,
  input  logic                           cfg_wr_en,
  input  logic [ipad_pkg::OUT_W-1:0]     cfg_wr_data
);

  ipad_pkg::state_t state;
  ipad_pkg::state_t state_next;

  logic [ipad_pkg::OUT_W-1:0]          period;
  logic signed [ipad_pkg::ACC_W-1:0]   acc_i;
  logic signed [ipad_pkg::ACC_W-1:0]   acc_q;
  logic [ipad_pkg::IDX_W-1:0]          tbl_idx;
  logic [ipad_pkg::CNT_W-1:0]          pair_cnt;
  logic signed [ipad_pkg::DIFF_W-1:0]  diff;
  logic signed [ipad_pkg::COEF_W-1:0]  cos_val;
  logic signed [ipad_pkg::COEF_W-1:0]  sin_val;
  logic                                last_q;
  logic signed [ipad_pkg::AVG_W-1:0]   iavg;
  logic signed [ipad_pkg::AVG_W-1:0]   qavg;
  logic [ipad_pkg::PROD_W-1:0]         sq_part;
  logic [ipad_pkg::PROD_W-1:0]         sq;
  logic [ipad_pkg::OUT_W-1:0]          mag;
  logic [ipad_pkg::OUT_W-1:0]          phase;
  logic [ipad_pkg::OUT_W-1:0]          delay;

  logic                                accept;
  logic                                acc_en;
  logic                                out_free;
  logic                                zero_vec;

  logic signed [ipad_pkg::MUL_W-1:0]   mul_a;
  logic signed [ipad_pkg::MUL_W-1:0]   mul_b;
  logic signed [ipad_pkg::PROD_W-1:0]  mul_p;

  logic                                div_start;
  logic signed [ipad_pkg::ACC_W-1:0]   div_acc;
  logic                                div_done;
  logic signed [ipad_pkg::AVG_W-1:0]   div_avg;

  logic                                sqrt_start;
  logic                                sqrt_done;
  logic [ipad_pkg::ROOT_W-1:0]         sqrt_root;

  logic                                cordic_start;
  logic                                cordic_done;
  logic signed [ipad_pkg::ANGLE_W-1:0] cordic_z;

  logic [ipad_pkg::ROOT_W:0]           mag_sum;
  logic [ipad_pkg::ANGLE_W-1:0]        phase_sum;
  logic [ipad_pkg::MUL_W-1:0]          delay_sum;

  ipad_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  ipad_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .acc   (div_acc),
    .n     (pair_cnt),
    .done  (div_done),
    .avg   (div_avg)
  );

  ipad_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .value (sq),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  ipad_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .i_in  (iavg),
    .q_in  (qavg),
    .done  (cordic_done),
    .z     (cordic_z)
  );

  // Pairs past the capacity are dropped from the sums but may still end it
  assign acc_en   = (pair_cnt < ipad_pkg::CNT_W'(ipad_pkg::MAX_PAIRS));
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign zero_vec = (iavg == '0) && (qavg == '0);

  always_comb begin
    mag_sum   = {1'b0, sqrt_root} + (ipad_pkg::ROOT_W + 1)'(ipad_pkg::MAG_ROUND);
    phase_sum = ipad_pkg::ANGLE_W'(8) - cordic_z;
    delay_sum = mul_p[ipad_pkg::MUL_W-1:0] + ipad_pkg::MUL_W'(ipad_pkg::DELAY_ROUND);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ipad_pkg::S_IDLE: begin
        if (in_valid) begin
          if (acc_en)
            state_next = ipad_pkg::S_MAC_I;
          else if (in_data.last)
            state_next = ipad_pkg::S_DIV_I_GO;
        end
      end
      ipad_pkg::S_MAC_I:    state_next = ipad_pkg::S_MAC_Q;
      ipad_pkg::S_MAC_Q:    state_next = ipad_pkg::S_MAC_END;
      ipad_pkg::S_MAC_END:  state_next = last_q ? ipad_pkg::S_DIV_I_GO : ipad_pkg::S_IDLE;
      ipad_pkg::S_DIV_I_GO: state_next = ipad_pkg::S_DIV_I_WAIT;
      ipad_pkg::S_DIV_I_WAIT: begin
        if (div_done)
          state_next = ipad_pkg::S_DIV_Q_GO;
      end
      ipad_pkg::S_DIV_Q_GO: state_next = ipad_pkg::S_DIV_Q_WAIT;
      ipad_pkg::S_DIV_Q_WAIT: begin
        if (div_done)
          state_next = ipad_pkg::S_SQ_I;
      end
      ipad_pkg::S_SQ_I:     state_next = ipad_pkg::S_SQ_Q;
      ipad_pkg::S_SQ_Q:     state_next = ipad_pkg::S_SQ_SUM;
      ipad_pkg::S_SQ_SUM:   state_next = ipad_pkg::S_SQRT_GO;
      ipad_pkg::S_SQRT_GO:  state_next = ipad_pkg::S_SQRT_WAIT;
      ipad_pkg::S_SQRT_WAIT: begin
        if (sqrt_done)
          state_next = zero_vec ? ipad_pkg::S_DELAY_MUL : ipad_pkg::S_CORDIC_GO;
      end
      ipad_pkg::S_CORDIC_GO: state_next = ipad_pkg::S_CORDIC_WAIT;
      ipad_pkg::S_CORDIC_WAIT: begin
        if (cordic_done)
          state_next = ipad_pkg::S_DELAY_MUL;
      end
      ipad_pkg::S_DELAY_MUL: state_next = ipad_pkg::S_DELAY_END;
      ipad_pkg::S_DELAY_END: state_next = ipad_pkg::S_OUT;
      ipad_pkg::S_OUT: begin
        if (out_free)
          state_next = ipad_pkg::S_IDLE;
      end
      default: state_next = ipad_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: steer the shared multiplier and kick the units
  always_comb begin
    in_ready     = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_acc      = acc_i;
    sqrt_start   = 1'b0;
    cordic_start = 1'b0;
    case (state)
      ipad_pkg::S_IDLE: in_ready = 1'b1;
      ipad_pkg::S_MAC_I: begin
        mul_a = ipad_pkg::MUL_W'(diff);
        mul_b = ipad_pkg::MUL_W'(cos_val);
      end
      ipad_pkg::S_MAC_Q: begin
        mul_a = ipad_pkg::MUL_W'(diff);
        mul_b = ipad_pkg::MUL_W'(sin_val);
      end
      ipad_pkg::S_DIV_I_GO: div_start = 1'b1;
      ipad_pkg::S_DIV_Q_GO: begin
        div_start = 1'b1;
        div_acc   = acc_q;
      end
      ipad_pkg::S_SQ_I: begin
        mul_a = iavg;
        mul_b = iavg;
      end
      ipad_pkg::S_SQ_Q: begin
        mul_a = qavg;
        mul_b = qavg;
      end
      ipad_pkg::S_SQRT_GO:   sqrt_start   = 1'b1;
      ipad_pkg::S_CORDIC_GO: cordic_start = 1'b1;
      ipad_pkg::S_DELAY_MUL: begin
        mul_a = $signed({{(ipad_pkg::MUL_W - ipad_pkg::OUT_W){1'b0}}, phase});
        mul_b = $signed({{(ipad_pkg::MUL_W - ipad_pkg::OUT_W){1'b0}}, period});
      end
      default: ;
    endcase
  end

  // Control state: sequencer, period, capture counters, sums, output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ipad_pkg::S_IDLE;
      period    <= ipad_pkg::PERIOD_RESET;
      acc_i     <= '0;
      acc_q     <= '0;
      tbl_idx   <= '0;
      pair_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en)
        period <= cfg_wr_data;
      if (accept && acc_en) begin
        tbl_idx  <= (tbl_idx == ipad_pkg::IDX_W'(ipad_pkg::TABLE_LENGTH - 1)) ?
                    '0 : tbl_idx + 1'b1;
        pair_cnt <= pair_cnt + 1'b1;
      end
      if (state == ipad_pkg::S_MAC_Q)
        acc_i <= acc_i + mul_p[ipad_pkg::ACC_W-1:0];
      if (state == ipad_pkg::S_MAC_END)
        acc_q <= acc_q + mul_p[ipad_pkg::ACC_W-1:0];
      // Hand off the result, then clear the capture
      if (state == ipad_pkg::S_OUT && out_free) begin
        out_valid <= 1'b1;
        acc_i     <= '0;
        acc_q     <= '0;
        tbl_idx   <= '0;
        pair_cnt  <= '0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      last_q  <= in_data.last;
      diff    <= $signed({1'b0, in_data.sample_a}) - $signed({1'b0, in_data.sample_b});
      cos_val <= ipad_pkg::cos_q15(tbl_idx);
      sin_val <= ipad_pkg::sin_q15(tbl_idx);
    end
    if (state == ipad_pkg::S_DIV_I_WAIT && div_done)
      iavg <= div_avg;
    if (state == ipad_pkg::S_DIV_Q_WAIT && div_done)
      qavg <= div_avg;
    if (state == ipad_pkg::S_SQ_Q)
      sq_part <= mul_p;
    if (state == ipad_pkg::S_SQ_SUM)
      sq <= sq_part + mul_p;
    if (state == ipad_pkg::S_SQRT_WAIT && sqrt_done) begin
      mag   <= (mag_sum[ipad_pkg::ROOT_W:ipad_pkg::MAG_SHIFT + ipad_pkg::OUT_W] != '0) ?
               '1 : mag_sum[ipad_pkg::MAG_SHIFT +: ipad_pkg::OUT_W];
      phase <= '0;
    end
    // Negate the angle, round to 1/65536 turn and wrap
    if (state == ipad_pkg::S_CORDIC_WAIT && cordic_done)
      phase <= phase_sum[4 +: ipad_pkg::OUT_W];
    if (state == ipad_pkg::S_DELAY_END)
      delay <= delay_sum[ipad_pkg::MUL_W-1 -: ipad_pkg::OUT_W];
    if (state == ipad_pkg::S_OUT && out_free) begin
      out_data.magnitude   <= mag;
      out_data.phase_turns <= phase;
      out_data.delay_ns    <= delay;
      out_data.pairs_used  <= pair_cnt;
    end
  end

endmodule

>>> design/ipad_checker.sv
// Port-level checker for the demodulator and its bind
`include "iq_phase_amplitude_demodulator_core_defines.svh"

module ipad_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input ipad_pkg::in_t               in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input ipad_pkg::out_t              out_data
);

  logic last_xact;
  logic out_stall;
  logic pairs_ok;

  assign last_xact = in_valid && in_ready && in_data.last;
  assign out_stall = out_valid && !out_ready;
  assign pairs_ok  = (out_data.pairs_used != '0) &&
                     (out_data.pairs_used <= ipad_pkg::CNT_W'(ipad_pkg::MAX_PAIRS));

  // A last transaction starts the finish, so the input closes
  `IPAD_ASSERT_NXT(a_busy_after_last, clk, rst, last_xact, !in_ready)
  // A stalled result holds
  `IPAD_ASSERT_NXT(a_out_hold, clk, rst, out_stall, out_valid && $stable(out_data))
  // Pair count is nonzero and stays within the capture capacity
  `IPAD_ASSERT_IMP(a_pairs_range, clk, rst, out_valid, pairs_ok)
  // Zero phase gives zero delay
  `IPAD_ASSERT_IMP(a_zero_delay, clk, rst, out_valid && (out_data.phase_turns == '0),
    out_data.delay_ns == '0)

endmodule

bind iq_phase_amplitude_demodulator_core ipad_checker u_ipad_checker (.*);

>>> test/tb_iq_phase_amplitude_demodulator_core.sv
// Testbench for the IQ phase and amplitude demodulator core
`timescale 1ns / 1ps

module tb_iq_phase_amplitude_demodulator_core;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ipad_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ipad_pkg::out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [ipad_pkg::OUT_W-1:0] cfg_wr_data = '0;

  iq_phase_amplitude_demodulator_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: accumulators, table position, pair count, drive period
  logic [47:0] sum_i, sum_q;
  int unsigned tbl_pos, pair_cnt;
  int unsigned period_ns;
  ipad_pkg::out_t capture_q[$];
  int errors = 0;
  bit long_hold = 1'b0;

  // Directed rows; has_exp marks rows whose result is typed in
  typedef struct {
    ipad_pkg::in_t  item;
    bit             has_exp;
    ipad_pkg::out_t exp;
  } row_t;
  row_t rows[$];

  function automatic longint sext48(logic [47:0] v);
    return longint'({{16{v[47]}}, v});
  endfunction

  function automatic longint avg_of(longint acc, int unsigned n);
    longint unsigned m, q;
    bit neg;
    neg = acc < 0;
    m = neg ? longint'(-acc) : acc;
    q = (m + n / 2) / n;
    if (neg) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      return -longint'(q);
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return longint'(q);
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint x, longint y);
    longint z, xs, ys;
    longint steps[18] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                          652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    z = 0;
    x = x <<< 24;
    y = y <<< 24;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = ipad_pkg::HALF_TURN;
    end
    for (int i = 0; i < 18; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += steps[i];
      end else begin
        x -= ys; y += xs; z -= steps[i];
      end
    end
    return z;
  endfunction

  // Advance the predictor by one pair; return 1 with the result on last
  function automatic bit demod_pair(ipad_pkg::in_t it, output ipad_pkg::out_t r);
    longint d, c, s, ia, qa, z;
    longint unsigned sq, mag, ph;
    int cosv[10] = '{32767, 26510, 10126, -10126, -26510, -32768, -26510, -10126,
                     10126, 26510};
    int sinv[10] = '{0, 19261, 31164, 31164, 19261, 0, -19261, -31164, -31164,
                     -19261};
    r = '0;
    if (pair_cnt < ipad_pkg::MAX_PAIRS) begin
      d = longint'(it.sample_a) - longint'(it.sample_b);
      c = cosv[tbl_pos];
      s = sinv[tbl_pos];
      sum_i = sum_i + 48'(d * c);
      sum_q = sum_q + 48'(d * s);
      tbl_pos = (tbl_pos + 1 >= ipad_pkg::TABLE_LENGTH) ? 0 : tbl_pos + 1;
      pair_cnt++;
    end
    if (!it.last) return 1'b0;
    ia = avg_of(sext48(sum_i), pair_cnt);
    qa = avg_of(sext48(sum_q), pair_cnt);
    sq = longint'(ia * ia) + longint'(qa * qa);
    mag = (floor_root(sq) + ipad_pkg::MAG_ROUND) >> ipad_pkg::MAG_SHIFT;
    if (mag > 65535) mag = 65535;
    if (ia == 0 && qa == 0) begin
      ph = 0;
    end else begin
      z = vector_angle(ia, qa);
      ph = ((64'd0 - longint'(z) + 8) >> 4) & 16'hFFFF;
    end
    r.magnitude = mag[15:0];
    r.phase_turns = ph[15:0];
    r.delay_ns = 16'((ph * period_ns + ipad_pkg::DELAY_ROUND) >> 16);
    r.pairs_used = pair_cnt[12:0];
    sum_i = '0; sum_q = '0; tbl_pos = 0; pair_cnt = 0;
    return 1'b1;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Offer one transaction and hold it until accepted; queue the expectation of a last one.
  // Valid stays high afterwards; a pause from pause_random or drain drops it.
  task automatic send_pair(ipad_pkg::in_t it, bit has_exp = 0,
                           ipad_pkg::out_t fixed = '0);
    ipad_pkg::out_t r;
    bit got;
    got = demod_pair(it, r);
    if (got) capture_q.push_back(has_exp ? fixed : r);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_random();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (capture_q.size() != 0) @(posedge clk);
    // let the block settle before anything else is written
    repeat (150) @(posedge clk);
  endtask

  task automatic write_period(logic [15:0] v);
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    period_ns = v;
  endtask

  function automatic ipad_pkg::in_t pick_pair(bit lst);
    ipad_pkg::in_t it;
    int m;
    m = $urandom_range(0, 9);
    it.sample_a = (m == 0) ? 16'hFFFF : (m == 1) ? 16'h0000 : 16'($urandom);
    it.sample_b = (m == 2) ? 16'hFFFF : (m == 3) ? 16'h0000 : 16'($urandom);
    it.last = lst;
    return it;
  endfunction

  // Send one capture of n pairs with random content
  task automatic send_capture(int n);
    for (int k = 1; k <= n; k++) begin
      send_pair(pick_pair(k == n));
      pause_random();
    end
  endtask

  function automatic row_t mk(logic [15:0] a, logic [15:0] b, bit l);
    row_t x;
    x.item = '{sample_a: a, sample_b: b, last: l};
    x.has_exp = 0;
    x.exp = '0;
    return x;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (1500) @(posedge clk);
        long_hold = 1'b0;
      end
      out_ready <= ($urandom_range(0, 3) != 0) || (gap_len() == 0);
    end
  end

  // Checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (capture_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        ipad_pkg::out_t e;
        e = capture_q.pop_front();
        if (out_data.magnitude !== e.magnitude) begin
          $display("%0t: magnitude expected %0d got %0d", $time, e.magnitude,
                   out_data.magnitude);
          errors++;
        end
        if (out_data.phase_turns !== e.phase_turns) begin
          $display("%0t: phase_turns expected %0d got %0d", $time, e.phase_turns,
                   out_data.phase_turns);
          errors++;
        end
        if (out_data.delay_ns !== e.delay_ns) begin
          $display("%0t: delay_ns expected %0d got %0d", $time, e.delay_ns,
                   out_data.delay_ns);
          errors++;
        end
        if (out_data.pairs_used !== e.pairs_used) begin
          $display("%0t: pairs_used expected %0d got %0d", $time, e.pairs_used,
                   out_data.pairs_used);
          errors++;
        end
      end
    end
  end

  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    row_t x;
    int sent;
    sum_i = '0; sum_q = '0; tbl_pos = 0; pair_cnt = 0;
    period_ns = ipad_pkg::PERIOD_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: zero vector, extremes, sign cases, full-period capture
    x = mk(16'h0000, 16'h0000, 1);
    x.has_exp = 1; x.exp = '{magnitude: 0, phase_turns: 0, delay_ns: 0, pairs_used: 1};
    rows.push_back(x);
    x = mk(16'h1234, 16'h1234, 1);
    x.has_exp = 1; x.exp = '{magnitude: 0, phase_turns: 0, delay_ns: 0, pairs_used: 1};
    rows.push_back(x);
    rows.push_back(mk(16'hFFFF, 16'h0000, 1));
    rows.push_back(mk(16'h0000, 16'hFFFF, 1));
    for (int k = 0; k < 10; k++) rows.push_back(mk(16'hFFFF, 16'h0000, k == 9));
    for (int k = 0; k < 3; k++) rows.push_back(mk(16'h0000, 16'hFFFF, k == 2));
    for (int k = 0; k < 4; k++) rows.push_back(mk(16'hAAAA, 16'h5555, k == 3));
    foreach (rows[k]) begin
      send_pair(rows[k].item, rows[k].has_exp, rows[k].exp);
      pause_random();
    end
    drain();

    // Past the capture capacity: MAX_PAIRS + extra pairs, the final one last
    write_period(16'd1);
    for (int k = 0; k < ipad_pkg::MAX_PAIRS + 5; k++)
      send_pair(pick_pair(k == ipad_pkg::MAX_PAIRS + 4));
    drain();

    // Sender pauses until every result arrives; then the receiver holds off
    write_period(16'hFFFF);
    send_capture(3);
    drain();
    long_hold = 1'b1;
    for (int k = 0; k < 12; k++) send_capture($urandom_range(1, 3));
    drain();

    // Random part: short captures mostly, longer ones now and then
    sent = 0;
    while (sent < 1700) begin
      int n;
      if ($urandom_range(0, 199) == 0) begin
        drain();
        case ($urandom_range(0, 3))
          0: write_period(16'd1);
          1: write_period(16'hFFFF);
          2: write_period(ipad_pkg::PERIOD_RESET);
          default: write_period(16'($urandom_range(1, 65535)));
        endcase
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
      send_capture(n);
      sent += n;
    end

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
